// ===== rtl/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// Shared constants and types for the subtractive lagged random generator.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int FRACTION_BITS_DEF = 32;

  // Lag table geometry and seeding walk
  localparam int TABLE_SIZE  = 55;
  localparam int LONG_LAG    = 31;
  localparam int SHORT_LAG   = 24;
  localparam int WALK_STRIDE = 21;
  localparam int WALK_MOD    = 54;
  localparam int ADDR_W      = $clog2(TABLE_SIZE);

  // Fixed field widths of the channels
  localparam int FIELD_W = 32;
  localparam int THR_W   = 33;

  // Walk start value, 1e-9 of one in units of 2^-32
  localparam logic [FIELD_W-1:0] START_UNITS = 32'd4;

  // Operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_ADDR = addr_t'(TABLE_SIZE - 1);

  // Table memory access request
  typedef struct packed {
    logic  we;
    addr_t waddr;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

endpackage

// ===== rtl/slr_in_if.sv =====
// ----------------------------------------------------------------------------
// slr_in_if
// Request channel: seed or draw transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slr_in_if import slr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [FIELD_W-1:0]        seed;
  logic [THR_W-1:0]          coin_threshold;
  logic signed [FIELD_W-1:0] range_low;
  logic signed [FIELD_W-1:0] range_high;

  modport source (output valid, op, seed, coin_threshold, range_low, range_high,
                  input ready);
  modport sink   (input valid, op, seed, coin_threshold, range_low, range_high,
                  output ready);
endinterface

// ===== rtl/slr_out_if.sv =====
// ----------------------------------------------------------------------------
// slr_out_if
// Result channel: one drawn number per draw transaction.
// ----------------------------------------------------------------------------
interface slr_out_if import slr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FIELD_W-1:0]        fraction;
  logic                      heads;
  logic signed [FIELD_W-1:0] pick;

  modport source (output valid, fraction, heads, pick, input ready);
  modport sink   (input valid, fraction, heads, pick, output ready);
endinterface

// ===== rtl/subtractive_lagged_random.sv =====
// ----------------------------------------------------------------------------
// subtractive_lagged_random
// Subtractive lagged generator (lags 55/24) built around a 55-entry table RAM.
// ----------------------------------------------------------------------------
//
//   Channel    Dir   Handshake     Payload
//   in_chan    in    valid/ready   op, seed, coin_threshold, range_low/high
//   out_chan   out   valid/ready   fraction, heads, pick
//
// Draw: accept with table read, multiply, then range add and clamp into the
//   output register; the next draw is accepted once the multiply stage has
//   emptied. A draw that finds the position at the last entry first refreshes
//   the table, one entry per cycle through the RAM's read-modify-write path.
// A seed transaction: accept, clear, walk, then three refresh passes.
// Reset: synchronous active-low; afterwards a clearing pass zeroes the table
//   before in_chan.ready rises.
// Stalls: the draw path holds two results (multiply stage and output
//   register); in_chan.ready is low outside idle and while the multiply stage
//   is occupied, so a held result backs up into the input.
// ----------------------------------------------------------------------------
module subtractive_lagged_random import slr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  slr_in_if.sink    in_chan,
  slr_out_if.source out_chan
);

  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [ADDR_W:0]          slot_sum_t;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CLEAR   = 3'd1;
  localparam logic [2:0] ST_WALK    = 3'd2;
  localparam logic [2:0] ST_REFRESH = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_MUL     = 3'd5;

  localparam addr_t     SHORT_A    = addr_t'(SHORT_LAG);
  localparam addr_t     LONG_A     = addr_t'(LONG_LAG);
  localparam addr_t     WALK_LAST  = addr_t'(WALK_MOD - 1);
  localparam addr_t     PASS_END   = addr_t'(TABLE_SIZE);
  localparam slot_sum_t STRIDE_X   = slot_sum_t'(WALK_STRIDE);
  localparam slot_sum_t MOD_X      = slot_sum_t'(WALK_MOD);

  // Control registers
  logic [2:0] state_r,     state_nxt;
  addr_t      cnt_r,       cnt_nxt;
  addr_t      slot_r,      slot_nxt;
  logic [1:0] passes_r,    passes_nxt;
  logic       draw_pend_r, draw_pend_nxt;
  logic       seeding_r,   seeding_nxt;
  addr_t      position_r,  position_nxt;
  logic       wv_r,        wv_nxt;

  // Payload registers
  addr_t                     wk_r,   wk_nxt;
  logic [FIELD_W-1:0]        seed_r, seed_nxt;
  frac_t                     prev_r, prev_nxt;
  frac_t                     next_r, next_nxt;
  logic [THR_W-1:0]          thr_r,  thr_nxt;
  logic signed [FIELD_W-1:0] low_r,  low_nxt;
  logic signed [FIELD_W-1:0] high_r, high_nxt;
  logic [FIELD_W:0]          span_r, span_nxt;

  // Datapath
  mem_req_t                    mem_req;
  frac_t                       wdata;
  frac_t                       rd_a;
  frac_t                       rd_b;
  logic [FRACTION_BITS+31:0]   seed_x;
  logic [FRACTION_BITS+31:0]   start_x;
  logic [FRACTION_BITS+31:0]   frac_x;
  frac_t                       seed_w;
  frac_t                       start_w;
  logic [FIELD_W-1:0]          frac32;
  frac_t                       diff;
  addr_t                       partner;
  slot_sum_t                   slot_sum;
  logic                        in_fire;
  logic                        draw_start;
  logic                        draw_busy;

  // Rescale 32-bit inputs to the table width and table values back to 32 bits:
  // the top bits of the value followed by zeros cover both directions.
  assign seed_x  = {seed_r, {FRACTION_BITS{1'b0}}};
  assign start_x = {START_UNITS, {FRACTION_BITS{1'b0}}};
  assign seed_w  = seed_x[FRACTION_BITS+31 -: FRACTION_BITS];
  assign start_w = start_x[FRACTION_BITS+31 -: FRACTION_BITS];
  assign frac_x  = {rd_a, 32'd0};
  assign frac32  = frac_x[FRACTION_BITS+31 -: FIELD_W];

  // Refresh partner: entry k+31 for the low 24 entries, k-24 above
  assign partner  = (cnt_r < SHORT_A) ? (cnt_r + LONG_A) : (cnt_r - SHORT_A);
  assign diff     = rd_a - rd_b;
  assign slot_sum = {1'b0, slot_r} + STRIDE_X;

  assign in_chan.ready = (state_r == ST_IDLE) && !draw_busy;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    passes_nxt    = passes_r;
    draw_pend_nxt = draw_pend_r;
    seeding_nxt   = seeding_r;
    position_nxt  = position_r;
    wv_nxt        = 1'b0;
    wk_nxt        = cnt_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    thr_nxt       = thr_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    span_nxt      = span_r;
    mem_req       = '0;
    wdata         = '0;
    draw_start    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        mem_req.raddr_a = position_r + addr_t'(1);
        if (in_fire) begin
          if (in_chan.op == OP_SEED) begin
            // Start over: clear, walk, three refreshes, position back to zero
            seeding_nxt  = 1'b1;
            seed_nxt     = in_chan.seed;
            position_nxt = '0;
            cnt_nxt      = '0;
            state_nxt    = ST_CLEAR;
          end else begin
            thr_nxt  = in_chan.coin_threshold;
            low_nxt  = in_chan.range_low;
            high_nxt = in_chan.range_high;
            span_nxt = {in_chan.range_high[FIELD_W-1], in_chan.range_high}
                     - {in_chan.range_low[FIELD_W-1], in_chan.range_low}
                     + {{FIELD_W{1'b0}}, 1'b1};
            if (position_r == LAST_ADDR) begin
              // Wrap: refresh the table, then read entry 1
              position_nxt  = addr_t'(1);
              passes_nxt    = 2'd1;
              draw_pend_nxt = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = ST_REFRESH;
            end else begin
              position_nxt = position_r + addr_t'(1);
              state_nxt    = ST_MUL;
            end
          end
        end
      end

      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        wdata         = (seeding_r && cnt_r == LAST_ADDR) ? seed_w : '0;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt = '0;
          if (seeding_r) begin
            slot_nxt  = addr_t'(WALK_STRIDE);
            prev_nxt  = seed_w;
            next_nxt  = start_w;
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + addr_t'(1);
        end
      end

      ST_WALK: begin
        // Write the running value, then advance the pair and the slot
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_r;
        wdata         = next_r;
        next_nxt      = prev_r - next_r;
        prev_nxt      = next_r;
        slot_nxt      = (slot_sum >= MOD_X) ? addr_t'(slot_sum - MOD_X)
                                            : addr_t'(slot_sum);
        if (cnt_r == WALK_LAST) begin
          cnt_nxt       = '0;
          passes_nxt    = 2'd3;
          draw_pend_nxt = 1'b0;
          seeding_nxt   = 1'b0;
          state_nxt     = ST_REFRESH;
        end else begin
          cnt_nxt = cnt_r + addr_t'(1);
        end
      end

      ST_REFRESH: begin
        // Read entry k and its partner, write the difference back in the following cycle
        mem_req.raddr_a = cnt_r;
        mem_req.raddr_b = partner;
        mem_req.we      = wv_r;
        mem_req.waddr   = wk_r;
        wdata           = diff;
        wv_nxt          = (cnt_r != PASS_END);
        if (cnt_r == PASS_END) begin
          cnt_nxt = '0;
          if (passes_r == 2'd1) begin
            state_nxt = draw_pend_r ? ST_READ : ST_IDLE;
          end
          passes_nxt = passes_r - 2'd1;
        end else begin
          cnt_nxt = cnt_r + addr_t'(1);
        end
      end

      ST_READ: begin
        mem_req.raddr_a = position_r;
        draw_pend_nxt   = 1'b0;
        state_nxt       = ST_MUL;
      end

      ST_MUL: begin
        // Read data is in; hand it to the draw datapath
        draw_start = 1'b1;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      slot_r      <= '0;
      passes_r    <= '0;
      draw_pend_r <= 1'b0;
      seeding_r   <= 1'b0;
      position_r  <= '0;
      wv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      passes_r    <= passes_nxt;
      draw_pend_r <= draw_pend_nxt;
      seeding_r   <= seeding_nxt;
      position_r  <= position_nxt;
      wv_r        <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r   <= wk_nxt;
    seed_r <= seed_nxt;
    prev_r <= prev_nxt;
    next_r <= next_nxt;
    thr_r  <= thr_nxt;
    low_r  <= low_nxt;
    high_r <= high_nxt;
    span_r <= span_nxt;
  end

  slr_mem #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .wdata (wdata),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  slr_draw u_draw (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (draw_start),
    .frac     (frac32),
    .thr      (thr_r),
    .low      (low_r),
    .high     (high_r),
    .span     (span_r),
    .busy     (draw_busy),
    .out_chan (out_chan)
  );

  // Position stays inside the table
  a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= LAST_ADDR)
    else $error("position past last table entry");

  // Refresh write-back never lands on an entry being read in the same cycle
  a_refresh_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFRESH && mem_req.we) |->
      (mem_req.waddr != mem_req.raddr_a && mem_req.waddr != mem_req.raddr_b))
    else $error("refresh write collides with a table read");

  // A draw enters the multiply stage only when that stage is free
  a_draw_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    draw_start |-> !draw_busy)
    else $error("draw started into an occupied multiply stage");

  // A draw without wrap reaches the multiply state in the next cycle
  a_draw_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.op == OP_DRAW && position_r != LAST_ADDR) |=>
      (state_r == ST_MUL))
    else $error("direct draw did not go to the multiply state");

endmodule

// ===== rtl/slr_mem.sv =====
// ----------------------------------------------------------------------------
// slr_mem
// Lag table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module slr_mem import slr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  mem_req_t                 req,
  input  logic [FRACTION_BITS-1:0] wdata,
  output logic [FRACTION_BITS-1:0] rd_a,
  output logic [FRACTION_BITS-1:0] rd_b
);

  logic [FRACTION_BITS-1:0] mem_r [TABLE_SIZE];
  logic [FRACTION_BITS-1:0] rd_a_r;
  logic [FRACTION_BITS-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= wdata;
    end
    rd_a_r <= mem_r[req.raddr_a];
    rd_b_r <= mem_r[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== rtl/slr_draw.sv =====
// ----------------------------------------------------------------------------
// slr_draw
// Draw datapath: multiply stage, then range add/clamp into the output register.
// ----------------------------------------------------------------------------
module slr_draw import slr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [FIELD_W-1:0]        frac,
  input  logic [THR_W-1:0]          thr,
  input  logic signed [FIELD_W-1:0] low,
  input  logic signed [FIELD_W-1:0] high,
  input  logic [FIELD_W:0]          span,
  output logic                      busy,
  slr_out_if.source                 out_chan
);

  // Multiply stage
  logic                      p_valid_r;
  logic [2*FIELD_W-1:0]      p_prod_r;
  logic [FIELD_W-1:0]        p_frac_r;
  logic                      p_heads_r;
  logic                      p_wide_r;
  logic                      p_flat_r;
  logic signed [FIELD_W-1:0] p_low_r;
  logic signed [FIELD_W-1:0] p_high_r;

  // Output register
  logic                      o_valid_r;
  logic [FIELD_W-1:0]        o_frac_r;
  logic                      o_heads_r;
  logic signed [FIELD_W-1:0] o_pick_r;

  logic                      advance;
  logic [FIELD_W-1:0]        offset;
  logic signed [FIELD_W+1:0] sum;
  logic signed [FIELD_W+1:0] high_x;
  logic signed [FIELD_W-1:0] pick_nxt;

  assign advance = p_valid_r && (!o_valid_r || out_chan.ready);
  assign busy    = p_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (start) begin
      p_valid_r <= 1'b1;
    end else if (advance) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_prod_r  <= frac * span[FIELD_W-1:0];
      p_frac_r  <= frac;
      p_heads_r <= ({1'b0, frac} <= thr);
      p_wide_r  <= span[FIELD_W];
      p_flat_r  <= (low >= high);
      p_low_r   <= low;
      p_high_r  <= high;
    end
  end

  // A full 2^32 span has a zero low word, so the offset is the fraction itself
  assign offset = p_wide_r ? p_frac_r : p_prod_r[2*FIELD_W-1:FIELD_W];
  assign sum    = {{2{p_low_r[FIELD_W-1]}}, p_low_r} + {2'b00, offset};
  assign high_x = {{2{p_high_r[FIELD_W-1]}}, p_high_r};

  always_comb begin
    if (p_flat_r) begin
      pick_nxt = p_low_r;
    end else if (sum > high_x) begin
      pick_nxt = p_high_r;
    end else begin
      pick_nxt = sum[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_frac_r  <= p_frac_r;
      o_heads_r <= p_heads_r;
      o_pick_r  <= pick_nxt;
    end
  end

  assign out_chan.valid    = o_valid_r;
  assign out_chan.fraction = o_frac_r;
  assign out_chan.heads    = o_heads_r;
  assign out_chan.pick     = o_pick_r;

endmodule
